// File: hw/rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared constants and types for the popcount count-up-to-limit block.
// ----------------------------------------------------------------------------
package pcl_pkg;

  // default width of the limit field
  localparam int LIMIT_BITS_DEF = 48;

  // width of the target weight field
  localparam int WEIGHT_W = 6;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

// File: hw/rtl/popcount_count_up_to_limit.sv
// ----------------------------------------------------------------------------
// popcount_count_up_to_limit
// Counts the integers 0..limit whose bit weight equals target_weight.
// The limit shifts out one bit per cycle, MSB first; each set bit that still
// needs weight adds a binomial read from the Pascal table.
// ----------------------------------------------------------------------------
// flow: an accepted word runs through ST_SCAN over every limit bit, then
//   ST_DRAIN, which waits for a free output register before out_valid rises;
//   a new word is taken only in ST_IDLE, once the count has left ST_DRAIN
// reset: synchronous, active low; afterwards the table fills and in_stall
//   stays high until the fill is done
module popcount_count_up_to_limit #(
  parameter int LIMIT_BITS = pcl_pkg::LIMIT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [LIMIT_BITS-1:0]         in_limit,
  input  logic [pcl_pkg::WEIGHT_W-1:0]  in_target_weight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [LIMIT_BITS:0]           out_count
);

  localparam int IW = $clog2(LIMIT_BITS);
  localparam int WW = pcl_pkg::WEIGHT_W;

  pcl_pkg::state_t state_r, state_nxt;

  logic [LIMIT_BITS-1:0] lim_r, lim_nxt;
  logic [WW-1:0]         rem_r, rem_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [LIMIT_BITS:0]   acc_r, acc_nxt;
  logic                  add_pend_r, add_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [LIMIT_BITS:0]   out_count_r, out_count_nxt;

  logic                  tbl_ready;
  logic [LIMIT_BITS-1:0] tbl_data;
  logic [LIMIT_BITS:0]   term;
  logic                  take;
  logic                  accept;
  logic                  out_free;

  pcl_binom_table #(
    .LIMIT_BITS(LIMIT_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .lk_row  (idx_r),
    .lk_col  (rem_r[IW-1:0]),
    .lk_data (tbl_data),
    .ready   (tbl_ready)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign take     = lim_r[LIMIT_BITS-1] && (rem_r != '0);
  assign term     = add_pend_r ? {1'b0, tbl_data} : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcl_pkg::ST_FILL: begin
        if (tbl_ready) begin
          state_nxt = pcl_pkg::ST_IDLE;
        end
      end
      pcl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pcl_pkg::ST_SCAN;
        end
      end
      pcl_pkg::ST_SCAN: begin
        if (idx_r == '0) begin
          state_nxt = pcl_pkg::ST_DRAIN;
        end
      end
      pcl_pkg::ST_DRAIN: begin
        if (out_free) begin
          state_nxt = pcl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcl_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    lim_nxt       = lim_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    add_pend_nxt  = 1'b0;
    out_count_nxt = out_count_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    unique case (state_r)
      pcl_pkg::ST_FILL: begin
        in_stall = 1'b1;
      end
      pcl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          lim_nxt = in_limit;
          rem_nxt = in_target_weight;
          idx_nxt = IW'(LIMIT_BITS - 1);
          acc_nxt = '0;
        end
      end
      pcl_pkg::ST_SCAN: begin
        acc_nxt = acc_r + term;
        lim_nxt = {lim_r[LIMIT_BITS-2:0], 1'b0};
        idx_nxt = idx_r - 1'b1;
        if (take) begin
          rem_nxt = rem_r - 1'b1;
          // weights past the table width have no matching x below this bit
          add_pend_nxt = (rem_r < WW'(LIMIT_BITS));
        end
      end
      pcl_pkg::ST_DRAIN: begin
        acc_nxt = acc_r + term;
        if (out_free) begin
          out_count_nxt = acc_r + term + (LIMIT_BITS + 1)'(rem_r == '0);
          out_valid_nxt = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcl_pkg::ST_FILL;
      add_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      add_pend_r  <= add_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    rem_r       <= rem_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

// File: hw/rtl/pcl_binom_table.sv
// ----------------------------------------------------------------------------
// pcl_binom_table
// Pascal triangle memory. Fills itself after reset, row by row, from the
// row above, then serves binomial lookups with a registered read.
// ----------------------------------------------------------------------------
module pcl_binom_table #(
  parameter int LIMIT_BITS = pcl_pkg::LIMIT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(LIMIT_BITS)-1:0] lk_row,
  input  logic [$clog2(LIMIT_BITS)-1:0] lk_col,
  output logic [LIMIT_BITS-1:0]         lk_data,
  output logic                          ready
);

  localparam int IW    = $clog2(LIMIT_BITS);
  localparam int DEPTH = 1 << (2 * IW);
  localparam logic [IW-1:0] LAST = IW'(LIMIT_BITS - 1);

  logic [LIMIT_BITS-1:0] mem [DEPTH];

  logic          fill_busy_r;
  logic [IW-1:0] fill_n_r, fill_n_nxt;
  logic [IW-1:0] fill_k_r, fill_k_nxt;
  logic          wr_pend_r;
  logic [2*IW-1:0] wr_addr_r;
  logic          wr_one_r;
  logic          wr_zero_r;

  logic [2*IW-1:0] addr_a, addr_b;
  logic [LIMIT_BITS-1:0] rda_r, rdb_r;
  logic [LIMIT_BITS-1:0] wr_data;

  // fill reads C(n-1,k-1) and C(n-1,k); afterwards port a serves lookups
  always_comb begin
    if (fill_busy_r) begin
      addr_a = {fill_n_r - 1'b1, fill_k_r - 1'b1};
    end else begin
      addr_a = {lk_row, lk_col};
    end
    addr_b = {fill_n_r - 1'b1, fill_k_r};
  end

  always_comb begin
    fill_k_nxt = fill_k_r + 1'b1;
    fill_n_nxt = fill_n_r;
    if (fill_k_r == LAST) begin
      fill_k_nxt = '0;
      fill_n_nxt = fill_n_r + 1'b1;
    end
  end

  always_comb begin
    if (wr_one_r) begin
      wr_data = LIMIT_BITS'(1);
    end else if (wr_zero_r) begin
      wr_data = '0;
    end else begin
      wr_data = rda_r + rdb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_n_r    <= '0;
      fill_k_r    <= '0;
      wr_pend_r   <= 1'b0;
    end else begin
      wr_pend_r <= fill_busy_r;
      if (fill_busy_r) begin
        fill_n_r <= fill_n_nxt;
        fill_k_r <= fill_k_nxt;
        if (fill_n_r == LAST && fill_k_r == LAST) begin
          fill_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= {fill_n_r, fill_k_r};
    wr_one_r  <= (fill_k_r == '0);
    wr_zero_r <= (fill_n_r == '0);
  end

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_addr_r] <= wr_data;
    end
    rda_r <= mem[addr_a];
    rdb_r <= mem[addr_b];
  end

  assign lk_data = rda_r;
  assign ready   = !fill_busy_r && !wr_pend_r;

endmodule

// File: hw/rtl/pcl_checker.sv
// ----------------------------------------------------------------------------
// pcl_checker
// Port-level checks for popcount_count_up_to_limit, attached by bind.
// ----------------------------------------------------------------------------
module pcl_checker #(
  parameter int LIMIT_BITS = pcl_pkg::LIMIT_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [LIMIT_BITS-1:0]         in_limit,
  input logic [pcl_pkg::WEIGHT_W-1:0]  in_target_weight,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [LIMIT_BITS:0]           out_count
);

  // reset leaves nothing to deliver and holds off new words during table fill
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("block not quiet after reset");

  // one word at a time: an accepted word keeps the input stalled next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while one is in work");

  // a count can never exceed two to the limit width
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count[LIMIT_BITS]) |-> (out_count[LIMIT_BITS-1:0] == '0))
    else $error("count out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_count)))
    else $error("stalled result word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_limit) && $stable(in_target_weight)))
    else $error("stalled input word changed");

endmodule

bind popcount_count_up_to_limit pcl_checker #(
  .LIMIT_BITS(LIMIT_BITS)
) u_pcl_checker (.*);

// File: tb/popcount_limit_checker.sv
// ----------------------------------------------------------------------------
// popcount_limit_checker
// Watches both channels of the popcount count-up-to-limit block. For every
// accepted input word it computes the expected count and queues it. Each
// accepted result word is compared with the oldest queued count.
// ----------------------------------------------------------------------------
module popcount_limit_checker #(
  parameter int LIMIT_BITS = pcl_pkg::LIMIT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [LIMIT_BITS-1:0]         in_limit,
  input  logic [pcl_pkg::WEIGHT_W-1:0]  in_target_weight,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [LIMIT_BITS:0]           out_count,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int MAX_REPORTS = 10;

  logic [LIMIT_BITS:0] pending_counts[$];

  // C(n, k), zero when k exceeds n
  function automatic longint unsigned choose(int n, int k);
    longint unsigned r;
    int kk;
    r = 1;
    kk = k;
    if (kk > n) begin
      return 0;
    end
    if (kk > n - kk) begin
      kk = n - kk;
    end
    for (int i = 0; i < kk; i++) begin
      r = r * longint'(n - i) / longint'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [LIMIT_BITS:0] count_with_weight(
    logic [LIMIT_BITS-1:0]        lim,
    logic [pcl_pkg::WEIGHT_W-1:0] weight
  );
    longint unsigned acc;
    int rem;
    bit stop;
    acc = 0;
    rem = int'(weight);
    stop = 1'b0;
    for (int b = LIMIT_BITS - 1; b >= 0; b--) begin
      if (!stop && lim[b]) begin
        if (rem == 0) begin
          // remaining weight used up: the rest of the scan adds nothing
          stop = 1'b1;
        end else begin
          acc += choose(b, rem);
          rem--;
        end
      end
    end
    if (rem == 0) begin
      acc += 1;
    end
    return acc[LIMIT_BITS:0];
  endfunction

  always @(posedge clk) begin
    logic [LIMIT_BITS:0] want;
    if (!rst_n) begin
      pending_counts.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_counts.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected result word: count %0d", out_count);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = pending_counts.pop_front();
          if (out_count !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $display("count mismatch: expected %0d, got %0d", want, out_count);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pending_counts.insert(pending_counts.size(),
                              count_with_weight(in_limit, in_target_weight));
      end
      outstanding <= pending_counts.size();
    end
  end

endmodule

// File: tb/popcount_count_up_to_limit_tb.sv
// ----------------------------------------------------------------------------
// popcount_count_up_to_limit_tb
// Drives limit and weight words into the popcount count-up-to-limit block:
// directed edge cases, then random words, many shaped around the limit's own
// bit weight. Both sides idle at random, and the receiver holds off for long
// stretches so the block backs up. The checker predicts every count.
// ----------------------------------------------------------------------------
module popcount_count_up_to_limit_tb;

  localparam int LB           = pcl_pkg::LIMIT_BITS_DEF;
  localparam int WW           = pcl_pkg::WEIGHT_W;
  localparam int RAND_WORDS   = 1600;
  localparam int PHASE_WORDS  = 200;
  localparam int CHOKE_CYCLES = 400;
  localparam int MAX_GAP      = 5;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [LB-1:0] in_limit;
  logic [WW-1:0] in_target_weight;
  logic          out_valid;
  logic          out_stall;
  logic [LB:0]   out_count;

  int mismatches;
  int outstanding;
  bit calm;
  int chokes_asked;

  popcount_count_up_to_limit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_limit         (in_limit),
    .in_target_weight (in_target_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_count        (out_count)
  );

  popcount_limit_checker #(
    .LIMIT_BITS (LB)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_limit         (in_limit),
    .in_target_weight (in_target_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_count        (out_count),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [LB-1:0] rand_limit();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[LB-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [LB-1:0] lim, logic [WW-1:0] weight);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_limit = lim;
    in_target_weight = weight;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // result side
  initial begin
    int gap;
    int chokes_done;
    chokes_done = 0;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (chokes_done < chokes_asked) begin
        out_stall = 1'b1;
        repeat (CHOKE_CYCLES) @(negedge clk);
        chokes_done++;
      end
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    int sel;
    int sh;
    int t;
    logic [LB-1:0] lim;
    logic [LB-1:0] ones;
    logic [WW-1:0] w;
    ones = '1;
    in_valid = 1'b0;
    in_limit = '0;
    in_target_weight = '0;
    calm = 1'b0;
    chokes_asked = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed edge cases
    send_word('0, '0);
    send_word('0, WW'(1));
    send_word(ones, '0);
    send_word(ones, WW'(1));
    send_word(ones, WW'(24));
    send_word(ones, WW'(47));
    send_word(ones, WW'(LB));
    send_word(ones, WW'(LB + 1));
    send_word(ones, '1);
    send_word(LB'(1), WW'(1));
    send_word(LB'(2), WW'(1));
    send_word(LB'(1) << (LB - 1), WW'(1));
    send_word(LB'(1) << (LB - 1), WW'(47));
    send_word(ones >> 1, WW'(47));
    send_word({(LB / 2){2'b01}}, WW'(24));
    send_word({(LB / 2){2'b10}}, WW'(24));
    send_word({(LB / 2){2'b10}}, WW'(25));
    send_word(rand_limit(), WW'(13));
    send_word(rand_limit(), WW'($urandom_range(LB + 1, 63)));
    send_word(rand_limit(), WW'($urandom_range(LB + 1, 63)));

    for (int i = 0; i < RAND_WORDS; i++) begin
      calm = ((i / PHASE_WORDS) % 2) == 1;
      if (i == PHASE_WORDS || i == 5 * PHASE_WORDS) begin
        chokes_asked++;
      end
      sel = $urandom_range(0, 9);
      lim = rand_limit();
      case (sel)
        0, 1, 2, 3: begin
          // weight close to the limit's own popcount hits the deep paths
          t = $countones(lim) + $urandom_range(0, 6) - 3;
        end
        4, 5: begin
          sh = $urandom_range(0, LB - 1);
          lim = lim >> sh;
          t = $urandom_range(0, LB - sh + 1);
        end
        6, 7: begin
          t = $urandom_range(0, 63);
        end
        8: begin
          lim = lim & rand_limit() & rand_limit();
          t = $urandom_range(0, 16);
        end
        default: begin
          lim = lim | rand_limit() | rand_limit();
          t = $urandom_range(30, LB + 2);
        end
      endcase
      if (t < 0) begin
        t = 0;
      end
      if (t > 63) begin
        t = 63;
      end
      w = WW'(t);
      send_word(lim, w);
    end
    in_valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (2 * LB + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
